@@ rtl/hid_keyboard_report_builder_core_defines.svh @@
// Assertion macros used by the report builder top level.
// Included by files that check their own logic; depends on nothing else.
`ifndef HID_KEYBOARD_REPORT_BUILDER_CORE_DEFINES_SVH
`define HID_KEYBOARD_REPORT_BUILDER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define HKRB_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define HKRB_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HKRB_ASSERT(label, clk, rst, prop, msg)
`define HKRB_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

@@ rtl/hkrb_pkg.sv @@
// Constants, types and helper functions of the keyboard report builder.
// Used by the interfaces, the slot file and the top level; depends on nothing.
`default_nettype none

package hkrb_pkg;

  localparam int KEY_SPACE = 256;
  localparam int REPORT_SLOTS = 6;
  localparam int VISIBLE_SLOTS = 6;

  localparam int KEY_IDX_W = $clog2(KEY_SPACE);
  localparam int SLOT_IDX_W = (REPORT_SLOTS > 1) ? $clog2(REPORT_SLOTS) : 1;

  localparam logic [7:0] MOD_FLAG = 8'h80;
  localparam logic [7:0] MOD_LOW = 8'h7F;
  localparam logic [7:0] EMPTY_SLOT = 8'h00;

  typedef logic [7:0] key_code_t;
  typedef logic [KEY_IDX_W-1:0] key_idx_t;
  typedef logic [SLOT_IDX_W-1:0] slot_idx_t;
  typedef logic [REPORT_SLOTS-1:0][7:0] slot_array_t;

  localparam key_idx_t KEY_LAST = key_idx_t'(KEY_SPACE - 1);
  localparam slot_idx_t SLOT_LAST = slot_idx_t'(REPORT_SLOTS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_DECIDE,
    ST_SCAN,
    ST_SHIFT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    slot_idx_t sel;
    key_code_t target;
    key_code_t data;
    logic wr;
    logic shift;
  } slot_cmd_t;

  function automatic logic [7:0] mod_mask(input key_code_t code);
    logic [7:0] m;
    m = code & MOD_LOW;
    return (m == 8'h00) ? MOD_FLAG : m;
  endfunction

  // Reduces a code modulo the key space by restoring subtraction.
  function automatic key_idx_t key_index(input key_code_t code);
    logic [16:0] r;
    r = {9'd0, code};
    for (int k = 7; k >= 0; k--) begin
      if (r >= (17'(KEY_SPACE) << k)) begin
        r = r - (17'(KEY_SPACE) << k);
      end
    end
    return r[KEY_IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/hkrb_if.sv @@
// Handshake channels of the report builder: key events in, reports out.
// Depends on hkrb_pkg for the payload types.
`default_nettype none

interface hkrb_key_if;
  logic valid;
  logic ready;
  hkrb_pkg::key_code_t key_code;
  logic is_press;

  modport source (output valid, output key_code, output is_press, input ready);
  modport sink (input valid, input key_code, input is_press, output ready);
endinterface

interface hkrb_report_if;
  logic valid;
  logic ready;
  logic [7:0] modifier_bits;
  logic [7:0] slot_one;
  logic [7:0] slot_two;
  logic [7:0] slot_three;
  logic [7:0] slot_four;
  logic [7:0] slot_five;
  logic [7:0] slot_six;

  modport source (
    output valid, output modifier_bits, output slot_one, output slot_two,
    output slot_three, output slot_four, output slot_five, output slot_six,
    input ready
  );
  modport sink (
    input valid, input modifier_bits, input slot_one, input slot_two,
    input slot_three, input slot_four, input slot_five, input slot_six,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/hkrb_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Holds the pressed-key map; depends on nothing.
`default_nettype none

module hkrb_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input wire logic clk,
  input wire logic we,
  input wire logic [$clog2(DEPTH)-1:0] waddr,
  input wire logic [WIDTH-1:0] wdata,
  input wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/hkrb_slots.sv @@
// Keycode slot file with one shared compare unit and a shift-down path.
// Depends on hkrb_pkg.
`default_nettype none

module hkrb_slots (
  input wire logic clk,
  input wire logic rst,
  input wire hkrb_pkg::slot_cmd_t cmd,
  output logic match,
  output hkrb_pkg::slot_array_t slots
);

  assign match = (slots[cmd.sel] == cmd.target);

  always_ff @(posedge clk) begin
    if (rst) begin
      slots <= '0;
    end else if (cmd.shift) begin
      for (int j = 0; j < hkrb_pkg::REPORT_SLOTS - 1; j++) begin
        if (hkrb_pkg::slot_idx_t'(j) >= cmd.sel) begin
          slots[j] <= slots[j + 1];
        end
      end
      slots[hkrb_pkg::REPORT_SLOTS - 1] <= hkrb_pkg::EMPTY_SLOT;
    end else if (cmd.wr) begin
      slots[cmd.sel] <= cmd.data;
    end
  end

endmodule

`default_nettype wire

@@ rtl/hid_keyboard_report_builder_core.sv @@
// Top level of the keyboard report builder: sequencer, modifier byte and report register.
// Depends on hkrb_pkg, hkrb_if, hkrb_ram, hkrb_slots and the assertion macro header.
`default_nettype none
`include "hid_keyboard_report_builder_core_defines.svh"

// Takes one key event per beat and returns a boot-keyboard report beat only when the
// modifier byte or a keycode slot changed. After reset the pressed-key map is cleared
// one entry per cycle, so no event is taken until every entry has been cleared.
// An event then passes the map lookup (ST_LOOKUP, ST_DECIDE) and ends there if it
// repeats the key state. A modifier loads the report (ST_EMIT) if the byte changed;
// an ordinary key first runs the slot search, visiting one slot per cycle through a
// single comparator, and on release a shift (ST_SHIFT). The report load waits for a
// free report register; a finished report waits there while the next event is taken.
module hid_keyboard_report_builder_core (
  input wire logic clk,
  input wire logic rst,
  hkrb_key_if.sink key,
  hkrb_report_if.source report
);

  hkrb_pkg::state_t state;
  hkrb_pkg::state_t state_next;
  hkrb_pkg::key_idx_t clr_cnt;
  hkrb_pkg::key_code_t code;
  logic press;
  hkrb_pkg::key_idx_t idx;
  hkrb_pkg::slot_idx_t cnt;
  logic [7:0] mod_state;
  logic [7:0] mod_next;
  logic out_valid;
  logic [7:0] out_mod;
  logic [hkrb_pkg::VISIBLE_SLOTS-1:0][7:0] out_slots;
  logic [hkrb_pkg::VISIBLE_SLOTS-1:0][7:0] vis;

  logic ram_we;
  hkrb_pkg::key_idx_t ram_waddr;
  logic ram_wdata;
  logic map_bit;
  hkrb_pkg::slot_cmd_t slot_cmd;
  logic match;
  hkrb_pkg::slot_array_t slots;
  logic accept;
  logic out_load;

  hkrb_ram #(
    .WIDTH(1),
    .DEPTH(hkrb_pkg::KEY_SPACE)
  ) u_map (
    .clk(clk),
    .we(ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(idx),
    .rdata(map_bit)
  );

  hkrb_slots u_slots (
    .clk(clk),
    .rst(rst),
    .cmd(slot_cmd),
    .match(match),
    .slots(slots)
  );

  for (genvar i = 0; i < hkrb_pkg::VISIBLE_SLOTS; i++) begin : g_vis
    if (i < hkrb_pkg::REPORT_SLOTS) begin : g_on
      assign vis[i] = slots[i];
    end else begin : g_off
      assign vis[i] = hkrb_pkg::EMPTY_SLOT;
    end
  end

  assign key.ready = (state == hkrb_pkg::ST_IDLE);
  assign accept = key.valid && key.ready;

  assign report.valid = out_valid;
  assign report.modifier_bits = out_mod;
  assign report.slot_one = out_slots[0];
  assign report.slot_two = out_slots[1];
  assign report.slot_three = out_slots[2];
  assign report.slot_four = out_slots[3];
  assign report.slot_five = out_slots[4];
  assign report.slot_six = out_slots[5];

  always_comb begin
    state_next = state;
    case (state)
      hkrb_pkg::ST_CLEAR: begin
        if (clr_cnt == hkrb_pkg::KEY_LAST) begin
          state_next = hkrb_pkg::ST_IDLE;
        end
      end
      hkrb_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = hkrb_pkg::ST_LOOKUP;
        end
      end
      hkrb_pkg::ST_LOOKUP: begin
        state_next = hkrb_pkg::ST_DECIDE;
      end
      hkrb_pkg::ST_DECIDE: begin
        if (map_bit == press) begin
          state_next = hkrb_pkg::ST_IDLE;
        end else if ((code & hkrb_pkg::MOD_FLAG) != 8'h00) begin
          state_next = (mod_next != mod_state) ? hkrb_pkg::ST_EMIT : hkrb_pkg::ST_IDLE;
        end else begin
          state_next = hkrb_pkg::ST_SCAN;
        end
      end
      hkrb_pkg::ST_SCAN: begin
        if (match) begin
          if (code == hkrb_pkg::EMPTY_SLOT) begin
            state_next = hkrb_pkg::ST_IDLE;
          end else begin
            state_next = press ? hkrb_pkg::ST_EMIT : hkrb_pkg::ST_SHIFT;
          end
        end else if (cnt == hkrb_pkg::SLOT_LAST) begin
          state_next = hkrb_pkg::ST_IDLE;
        end
      end
      hkrb_pkg::ST_SHIFT: begin
        state_next = hkrb_pkg::ST_EMIT;
      end
      hkrb_pkg::ST_EMIT: begin
        if (out_load) begin
          state_next = hkrb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = hkrb_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = idx;
    ram_wdata = press;
    slot_cmd.sel = cnt;
    slot_cmd.target = press ? hkrb_pkg::EMPTY_SLOT : code;
    slot_cmd.data = code;
    slot_cmd.wr = 1'b0;
    slot_cmd.shift = 1'b0;
    mod_next = press ? (mod_state | hkrb_pkg::mod_mask(code))
                     : (mod_state ^ hkrb_pkg::mod_mask(code));
    out_load = 1'b0;
    case (state)
      hkrb_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = 1'b0;
      end
      hkrb_pkg::ST_DECIDE: begin
        ram_we = (map_bit != press);
      end
      hkrb_pkg::ST_SCAN: begin
        slot_cmd.wr = press && match;
      end
      hkrb_pkg::ST_SHIFT: begin
        slot_cmd.shift = 1'b1;
      end
      hkrb_pkg::ST_EMIT: begin
        out_load = !out_valid || report.ready;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hkrb_pkg::ST_CLEAR;
      clr_cnt <= '0;
      cnt <= '0;
      mod_state <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == hkrb_pkg::ST_CLEAR) begin
        clr_cnt <= clr_cnt + hkrb_pkg::key_idx_t'(1);
      end
      if (state == hkrb_pkg::ST_DECIDE) begin
        cnt <= '0;
        if (map_bit != press && (code & hkrb_pkg::MOD_FLAG) != 8'h00) begin
          mod_state <= mod_next;
        end
      end
      if (state == hkrb_pkg::ST_SCAN && !match && cnt != hkrb_pkg::SLOT_LAST) begin
        cnt <= cnt + hkrb_pkg::slot_idx_t'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (report.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      code <= key.key_code;
      press <= key.is_press;
      idx <= hkrb_pkg::key_index(key.key_code);
    end
    if (out_load) begin
      out_mod <= mod_state;
      out_slots <= vis;
    end
  end

  `HKRB_ASSERT(a_mod_changed, clk, rst, (state == hkrb_pkg::ST_DECIDE && state_next == hkrb_pkg::ST_EMIT) |=> (mod_state != $past(mod_state)), "modifier report without a modifier change")
  `HKRB_ASSERT(a_scan_bound, clk, rst, (state == hkrb_pkg::ST_SCAN) |-> (cnt <= hkrb_pkg::SLOT_LAST), "slot search ran past the last slot")
  `HKRB_ASSERT(a_emit_load, clk, rst, out_load |=> (out_valid && state == hkrb_pkg::ST_IDLE), "report load did not present a beat")
  `HKRB_ASSERT(a_shift_tail, clk, rst, slot_cmd.shift |=> (slots[hkrb_pkg::REPORT_SLOTS - 1] == hkrb_pkg::EMPTY_SLOT), "last slot not emptied by a removal")

endmodule

`default_nettype wire

@@ tb/sv/hid_keyboard_report_builder_core_test.sv @@
// Self-checking test of the keyboard report builder core: key event beats in, report beats out.
// Depends on hkrb_pkg, the hkrb_key_if and hkrb_report_if interfaces and the core itself.
`timescale 1ns / 1ps

module hid_keyboard_report_builder_core_test;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_EVENTS = 800;
  localparam int POOL_SIZE = 10;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_REPORT, ROW_SILENT} row_kind_t;

  typedef struct packed {
    logic [7:0] mods;
    logic [47:0] keys;
  } key_report_t;

  typedef struct {
    hkrb_pkg::key_code_t code;
    logic press;
    row_kind_t kind;
    logic [7:0] mods;
    logic [47:0] keys;
  } key_row_t;

  key_row_t script [25] = '{
    '{8'h04, 1'b1, ROW_REPORT, 8'h00, 48'h04_00_00_00_00_00},
    '{8'h04, 1'b1, ROW_SILENT, 8'h00, 48'h0},
    '{8'h05, 1'b0, ROW_SILENT, 8'h00, 48'h0},
    '{8'h80, 1'b1, ROW_REPORT, 8'h80, 48'h04_00_00_00_00_00},
    '{8'hFF, 1'b1, ROW_REPORT, 8'hFF, 48'h04_00_00_00_00_00},
    '{8'h80, 1'b0, ROW_REPORT, 8'h7F, 48'h04_00_00_00_00_00},
    '{8'h81, 1'b1, ROW_SILENT, 8'h00, 48'h0},
    '{8'h81, 1'b0, ROW_REPORT, 8'h7E, 48'h04_00_00_00_00_00},
    '{8'hFF, 1'b0, ROW_REPORT, 8'h01, 48'h04_00_00_00_00_00},
    '{8'h00, 1'b1, ROW_SILENT, 8'h00, 48'h0},
    '{8'h7F, 1'b1, ROW_REPORT, 8'h01, 48'h04_7F_00_00_00_00},
    '{8'h05, 1'b1, ROW_PREDICT, 8'h00, 48'h0},
    '{8'h06, 1'b1, ROW_PREDICT, 8'h00, 48'h0},
    '{8'h07, 1'b1, ROW_PREDICT, 8'h00, 48'h0},
    '{8'h08, 1'b1, ROW_REPORT, 8'h01, 48'h04_7F_05_06_07_08},
    '{8'h09, 1'b1, ROW_SILENT, 8'h00, 48'h0},
    '{8'h09, 1'b0, ROW_SILENT, 8'h00, 48'h0},
    '{8'h7F, 1'b0, ROW_REPORT, 8'h01, 48'h04_05_06_07_08_00},
    '{8'h00, 1'b0, ROW_SILENT, 8'h00, 48'h0},
    '{8'h04, 1'b0, ROW_PREDICT, 8'h00, 48'h0},
    '{8'h05, 1'b0, ROW_PREDICT, 8'h00, 48'h0},
    '{8'h06, 1'b0, ROW_PREDICT, 8'h00, 48'h0},
    '{8'h07, 1'b0, ROW_PREDICT, 8'h00, 48'h0},
    '{8'h08, 1'b0, ROW_PREDICT, 8'h00, 48'h0},
    '{8'h81, 1'b1, ROW_SILENT, 8'h00, 48'h0}
  };

  logic clk;
  logic rst;
  bit quiet;
  int errors;
  int cycle_count;

  logic [hkrb_pkg::KEY_SPACE-1:0] keys_down;
  logic [7:0] held_mods;
  hkrb_pkg::slot_array_t held_keys;
  key_report_t reports_due [$];

  hkrb_key_if key_ch ();
  hkrb_report_if report_ch ();

  hid_keyboard_report_builder_core dut (
    .clk(clk),
    .rst(rst),
    .key(key_ch),
    .report(report_ch)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic bit advance_keyboard(input hkrb_pkg::key_code_t code, input logic press,
                                          output key_report_t rep);
    int idx;
    int hit;
    bit placed;
    logic [7:0] mask;
    logic [7:0] mods_before;
    hkrb_pkg::slot_array_t keys_before;
    idx = int'(code) % hkrb_pkg::KEY_SPACE;
    mods_before = held_mods;
    keys_before = held_keys;
    mask = ((code & hkrb_pkg::MOD_LOW) == 8'h00) ? hkrb_pkg::MOD_FLAG
                                                  : (code & hkrb_pkg::MOD_LOW);
    if (press && !keys_down[idx]) begin
      keys_down[idx] = 1'b1;
      if (code[7]) begin
        held_mods = held_mods | mask;
      end else begin
        placed = 1'b0;
        for (int i = 0; i < hkrb_pkg::REPORT_SLOTS; i++) begin
          if (!placed && held_keys[i] == hkrb_pkg::EMPTY_SLOT) begin
            held_keys[i] = code;
            placed = 1'b1;
          end
        end
      end
    end else if (!press && keys_down[idx]) begin
      keys_down[idx] = 1'b0;
      if (code[7]) begin
        held_mods = held_mods ^ mask;
      end else begin
        hit = -1;
        for (int i = 0; i < hkrb_pkg::REPORT_SLOTS; i++) begin
          if (hit < 0 && held_keys[i] == code) hit = i;
        end
        if (hit >= 0) begin
          for (int j = hit; j < hkrb_pkg::REPORT_SLOTS - 1; j++) begin
            held_keys[j] = held_keys[j + 1];
          end
          held_keys[hkrb_pkg::REPORT_SLOTS - 1] = hkrb_pkg::EMPTY_SLOT;
        end
      end
    end
    rep.mods = held_mods;
    rep.keys = '0;
    for (int i = 0; i < 6 && i < hkrb_pkg::REPORT_SLOTS; i++) begin
      rep.keys[47 - 8 * i -: 8] = held_keys[i];
    end
    return !(mods_before == held_mods && keys_before == held_keys);
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %02h, got %02h", $time, name, want, got);
    end
  endtask

  task automatic send_key(input hkrb_pkg::key_code_t code, input logic press,
                          input row_kind_t kind, input key_report_t typed);
    int gap;
    key_report_t rep;
    bit changed;
    gap = (!quiet && $urandom_range(0, 99) < 8) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      key_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    key_ch.key_code <= code;
    key_ch.is_press <= press;
    key_ch.valid <= 1'b1;
    do @(posedge clk); while (key_ch.ready !== 1'b1);
    changed = advance_keyboard(code, press, rep);
    if (kind == ROW_REPORT) begin
      reports_due.push_back(typed);
    end else if (kind == ROW_PREDICT && changed) begin
      reports_due.push_back(rep);
    end
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    report_ch.ready <= !rst && (quiet || $urandom_range(0, 99) >= 8);
  end

  always @(posedge clk) begin
    key_report_t got;
    key_report_t want;
    if (!rst && report_ch.valid === 1'b1 && report_ch.ready === 1'b1) begin
      got.mods = report_ch.modifier_bits;
      got.keys = {report_ch.slot_one, report_ch.slot_two, report_ch.slot_three,
                  report_ch.slot_four, report_ch.slot_five, report_ch.slot_six};
      if (reports_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected report beat, expected none, got mods %02h keys %012h",
                 $time, got.mods, got.keys);
      end else begin
        want = reports_due.pop_front();
        check_field("modifier_bits", want.mods, got.mods);
        for (int i = 0; i < 6; i++) begin
          check_field($sformatf("slot %0d", i + 1), want.keys[47 - 8 * i -: 8],
                      got.keys[47 - 8 * i -: 8]);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    hkrb_pkg::key_code_t pool [POOL_SIZE];
    hkrb_pkg::key_code_t code;
    logic press;
    rst = 1'b1;
    quiet = 1'b0;
    errors = 0;
    cycle_count = 0;
    keys_down = '0;
    held_mods = '0;
    held_keys = '0;
    key_ch.valid = 1'b0;
    key_ch.key_code = '0;
    key_ch.is_press = 1'b0;
    report_ch.ready = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (script[r]) begin
      send_key(script[r].code, script[r].press, script[r].kind,
               '{mods: script[r].mods, keys: script[r].keys});
    end

    for (int n = 0; n < RANDOM_EVENTS; n++) begin
      if (n % 100 == 0) begin
        for (int i = 0; i < POOL_SIZE; i++) begin
          pool[i] = (i < 3) ? hkrb_pkg::key_code_t'($urandom_range(128, 255))
                            : hkrb_pkg::key_code_t'($urandom_range(0, 127));
        end
      end
      quiet = (n >= 300 && n < 450);
      if (n == 500) begin
        key_ch.valid <= 1'b0;
        while (reports_due.size() != 0) @(negedge clk);
      end
      code = ($urandom_range(0, 99) < 75) ? pool[$urandom_range(0, POOL_SIZE - 1)]
                                          : hkrb_pkg::key_code_t'($urandom_range(0, 255));
      press = ($urandom_range(0, 99) < 55);
      send_key(code, press, ROW_PREDICT, '0);
    end
    key_ch.valid <= 1'b0;

    while (reports_due.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ hid_keyboard_report_builder_core.f @@
+incdir+rtl
rtl/hkrb_pkg.sv
rtl/hkrb_if.sv
rtl/hkrb_ram.sv
rtl/hkrb_slots.sv
rtl/hid_keyboard_report_builder_core.sv
tb/sv/hid_keyboard_report_builder_core_test.sv
